/* src/sgr_pkg.sv */
// Shared types, constants and codes of the scaled glyph row renderer.
// No dependencies; all files but sgr_ram and sgr_checker use its scoped names.
package sgr_pkg;

    // Scale limits applied when a scale register is written
    localparam int MAX_WIDTH  = 8;
    localparam int MAX_HEIGHT = 8;
    // Default font store depth in bytes
    localparam int FONT_DEPTH = 4096;

    localparam logic [7:0] NEWLINE_SYM = 8'd10;

    // Configuration register indexes
    localparam logic [2:0] REG_LARGE_FONT    = 3'd0;
    localparam logic [2:0] REG_WIDTH_SCALE   = 3'd1;
    localparam logic [2:0] REG_HEIGHT_SCALE  = 3'd2;
    localparam logic [2:0] REG_SLANT_MODE    = 3'd3;
    localparam logic [2:0] REG_INVERT_PIXELS = 3'd4;
    localparam logic [2:0] REG_FORE_SYMBOL   = 3'd5;
    localparam logic [2:0] REG_BACK_SYMBOL   = 3'd6;

    // Input item kinds
    localparam logic KIND_FONT_WRITE = 1'b0;
    localparam logic KIND_RENDER     = 1'b1;

    // Slant codes
    localparam logic [1:0] SLANT_UPRIGHT = 2'd0;
    localparam logic [1:0] SLANT_CURSIVE = 2'd1;
    localparam logic [1:0] SLANT_BACK    = 2'd2;

    typedef struct packed {
        logic       large_font;
        logic [3:0] width_scale;
        logic [3:0] height_scale;
        logic [1:0] slant_mode;
        logic       invert_pixels;
        logic [7:0] fore_symbol;
        logic [7:0] back_symbol;
    } cfg_t;

    // One classified render job, handed from front to back
    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] char_code;
        logic [6:0] lead_cnt;
        logic [6:0] trail_cnt;
        logic       first_in_row;
        logic       last_in_row;
    } entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_READ,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PIX,
        PH_TRAIL,
        PH_NL
    } back_state_t;

endpackage

/* src/sgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sgr_front.sv */
// Front end: accepts items, writes the font store, divides the line index by
// the height scale, reads the glyph row and pushes a job. Uses sgr_pkg, sgr_ram.
module sgr_front #(
    parameter int FONT_DEPTH = sgr_pkg::FONT_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sgr_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [11:0]         s_font_address,
    input  logic [7:0]          s_font_byte,
    input  logic [7:0]          s_char_code,
    input  logic [6:0]          s_line_index,
    input  logic                s_first_in_row,
    input  logic                s_last_in_row,
    output logic                push_valid,
    input  logic                push_ready,
    output sgr_pkg::entry_t     push_data
);

    localparam int AW = $clog2(FONT_DEPTH);
    localparam logic [13:0] DEPTH_1X = 14'(FONT_DEPTH);
    localparam logic [13:0] DEPTH_2X = 14'(2 * FONT_DEPTH);

    sgr_pkg::front_state_t state_reg, state_next;

    logic [3:0] div_rem_reg, div_rem_next;
    logic [7:0] div_quo_reg, div_quo_next;
    logic [1:0] step_reg, step_next;
    logic [7:0] char_reg;
    logic [6:0] line_reg;
    logic       first_reg;
    logic       last_reg;

    logic        accept;
    logic        start_render;
    logic        ram_wr_en;
    logic [13:0] wr_addr_full;
    logic [13:0] glyph_base;
    logic [13:0] rd_addr_full;
    logic [7:0]  ram_rd_data;
    logic [7:0]  lines;
    logic [8:0]  far_diff;
    logic [6:0]  cnt_far;

    // Fold an address below three depths back into the store
    function automatic logic [13:0] wrap_addr(input logic [13:0] a);
        if (a >= DEPTH_2X) begin
            return a - DEPTH_2X;
        end else if (a >= DEPTH_1X) begin
            return a - DEPTH_1X;
        end else begin
            return a;
        end
    endfunction

    // Two restoring division steps: {remainder, shifting dividend/quotient}
    function automatic logic [11:0] div_two(input logic [3:0] rem, input logic [7:0] quo,
                                            input logic [3:0] dvs);
        logic [4:0] t;
        logic [3:0] r;
        logic [7:0] q;
        logic       ge;
        r = rem;
        q = quo;
        for (int i = 0; i < 2; i++) begin
            t  = {r, q[7]};
            ge = (t >= {1'b0, dvs});
            r  = ge ? 4'(t - {1'b0, dvs}) : t[3:0];
            q  = {q[6:0], ge};
        end
        return {r, q};
    endfunction

    assign accept       = s_valid && s_ready;
    assign start_render = accept && (s_kind == sgr_pkg::KIND_RENDER);
    assign ram_wr_en    = accept && (s_kind == sgr_pkg::KIND_FONT_WRITE);
    assign wr_addr_full = wrap_addr({2'b00, s_font_address});

    assign glyph_base   = cfg.large_font ? {2'b00, char_reg, 4'b0000}
                                         : {3'b000, char_reg, 3'b000};
    assign rd_addr_full = wrap_addr(glyph_base + {6'd0, div_quo_reg});

    sgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr_full[AW-1:0]),
        .wr_data (s_font_byte),
        .rd_en   (state_reg == sgr_pkg::F_READ),
        .rd_addr (rd_addr_full[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Padding counts: far side is lines - line - 1, saturated to 0..127
    assign lines    = cfg.large_font ? {cfg.height_scale, 4'b0000}
                                     : {1'b0, cfg.height_scale, 3'b000};
    assign far_diff = {1'b0, lines} - {2'b00, line_reg} - 9'd1;
    always_comb begin
        if (far_diff[8]) begin
            cnt_far = 7'd0;
        end else if (far_diff[7]) begin
            cnt_far = 7'd127;
        end else begin
            cnt_far = far_diff[6:0];
        end
    end

    always_comb begin
        push_data.glyph        = ram_rd_data;
        push_data.char_code    = char_reg;
        push_data.first_in_row = first_reg;
        push_data.last_in_row  = last_reg;
        if (cfg.slant_mode == sgr_pkg::SLANT_CURSIVE) begin
            push_data.lead_cnt  = cnt_far;
            push_data.trail_cnt = line_reg;
        end else begin
            push_data.lead_cnt  = line_reg;
            push_data.trail_cnt = cnt_far;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        push_valid   = 1'b0;
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        step_next    = step_reg;
        unique case (state_reg)
            sgr_pkg::F_IDLE: begin
                s_ready = 1'b1;
                if (start_render) begin
                    state_next = sgr_pkg::F_DIV;
                end
            end
            sgr_pkg::F_DIV: begin
                {div_rem_next, div_quo_next} = div_two(div_rem_reg, div_quo_reg,
                                                       cfg.height_scale);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = sgr_pkg::F_READ;
                end
            end
            sgr_pkg::F_READ: begin
                state_next = sgr_pkg::F_PUSH;
            end
            sgr_pkg::F_PUSH: begin
                push_valid = 1'b1;
                s_ready    = push_ready;
                if (push_ready) begin
                    state_next = start_render ? sgr_pkg::F_DIV : sgr_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = sgr_pkg::F_IDLE;
            end
        endcase
        // Load the divider on a new render job
        if (start_render) begin
            div_rem_next = 4'd0;
            div_quo_next = {1'b0, s_line_index};
            step_next    = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgr_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        step_reg    <= step_next;
        if (start_render) begin
            char_reg  <= s_char_code;
            line_reg  <= s_line_index;
            first_reg <= s_first_in_row;
            last_reg  <= s_last_in_row;
        end
    end

endmodule

/* src/sgr_queue.sv */
// Two-entry job queue between front and back end.
// Uses sgr_pkg for the job type.
module sgr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sgr_pkg::entry_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sgr_pkg::entry_t out_data
);

    sgr_pkg::entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* src/sgr_back.sv */
// Back end: sequences one job into padding, pixel and newline runs and holds
// each run in the output register. Uses sgr_pkg.
module sgr_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  sgr_pkg::cfg_t   cfg,
    input  logic            job_valid,
    output logic            job_ready,
    input  sgr_pkg::entry_t job_data,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_symbol,
    output logic [6:0]      m_repeat_count,
    output logic            m_last
);

    sgr_pkg::back_state_t ph_reg, ph_next, ph_after;
    sgr_pkg::entry_t      cur_reg, cur_next;
    logic [2:0] pix_reg, pix_next;
    logic [7:0] glyph_reg, glyph_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_symbol_reg, m_symbol_next;
    logic [6:0] m_count_reg, m_count_next;
    logic       m_last_reg, m_last_next;

    logic       slanted;
    logic       active;
    logic       pop;
    logic [7:0] pad_sym;
    logic [7:0] set_sym;
    logic [7:0] res_sym;
    logic [6:0] res_cnt;
    logic       res_last;

    assign slanted = (cfg.slant_mode == sgr_pkg::SLANT_CURSIVE) ||
                     (cfg.slant_mode == sgr_pkg::SLANT_BACK);
    assign pad_sym = cfg.invert_pixels ? cfg.fore_symbol : cfg.back_symbol;
    assign set_sym = (cfg.fore_symbol != 8'd0) ? cfg.fore_symbol : cur_reg.char_code;
    assign active  = (ph_reg != sgr_pkg::PH_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        res_sym  = cfg.back_symbol;
        res_cnt  = {3'b000, cfg.width_scale};
        res_last = 1'b0;
        ph_after = sgr_pkg::PH_IDLE;
        unique case (ph_reg)
            sgr_pkg::PH_IDLE: begin
                ph_after = sgr_pkg::PH_IDLE;
            end
            sgr_pkg::PH_LEAD: begin
                res_sym  = pad_sym;
                res_cnt  = cur_reg.lead_cnt;
                ph_after = sgr_pkg::PH_PIX;
            end
            sgr_pkg::PH_PIX: begin
                res_sym = (glyph_reg[7] ^ cfg.invert_pixels) ? set_sym : cfg.back_symbol;
                if (pix_reg == 3'd7) begin
                    res_last = !cur_reg.last_in_row;
                    if (!cur_reg.last_in_row) begin
                        ph_after = sgr_pkg::PH_IDLE;
                    end else if (slanted) begin
                        ph_after = sgr_pkg::PH_TRAIL;
                    end else begin
                        ph_after = sgr_pkg::PH_NL;
                    end
                end else begin
                    ph_after = sgr_pkg::PH_PIX;
                end
            end
            sgr_pkg::PH_TRAIL: begin
                res_sym  = pad_sym;
                res_cnt  = cur_reg.trail_cnt;
                ph_after = sgr_pkg::PH_NL;
            end
            sgr_pkg::PH_NL: begin
                res_sym  = sgr_pkg::NEWLINE_SYM;
                res_cnt  = 7'd1;
                res_last = 1'b1;
                ph_after = sgr_pkg::PH_IDLE;
            end
            default: begin
                ph_after = sgr_pkg::PH_IDLE;
            end
        endcase
    end

    // Take the next job when idle or in the cycle the current one finishes
    assign pop = job_valid &&
                 ((ph_reg == sgr_pkg::PH_IDLE) || (active && ph_after == sgr_pkg::PH_IDLE));
    assign job_ready = pop;

    always_comb begin
        ph_next       = ph_reg;
        pix_next      = pix_reg;
        glyph_next    = glyph_reg;
        cur_next      = cur_reg;
        m_symbol_next = m_symbol_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        if (active) begin
            ph_next       = ph_after;
            m_valid_next  = 1'b1;
            m_symbol_next = res_sym;
            m_count_next  = res_cnt;
            m_last_next   = res_last;
            if (ph_reg == sgr_pkg::PH_PIX) begin
                pix_next   = pix_reg + 3'd1;
                glyph_next = {glyph_reg[6:0], 1'b0};
            end
        end
        if (pop) begin
            cur_next   = job_data;
            glyph_next = job_data.glyph;
            pix_next   = 3'd0;
            ph_next    = (job_data.first_in_row && slanted) ? sgr_pkg::PH_LEAD
                                                            : sgr_pkg::PH_PIX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= sgr_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        glyph_reg    <= glyph_next;
        cur_reg      <= cur_next;
        m_symbol_reg <= m_symbol_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol       = m_symbol_reg;
    assign m_repeat_count = m_count_reg;
    assign m_last         = m_last_reg;

endmodule

/* src/scaled_glyph_row_renderer_unit.sv */
// Scaled glyph row renderer: font store, configuration registers, front end,
// job queue and run sequencer. Uses sgr_pkg, sgr_front, sgr_queue, sgr_back.
// Path: a render transaction passes the divider, font read, queue write, job pop
// and output register before its first result; a font write is stored on accept.
// Throughput: one result per cycle from the run sequencer unless m_ready stalls,
// and 8 to 11 results per render transaction; the front end takes a new render
// transaction only once it has pushed the last one.
// Reset: synchronous, clears control state and restores register defaults;
// the font store keeps its content and is undefined until written.
module scaled_glyph_row_renderer_unit #(
    parameter int FONT_DEPTH = sgr_pkg::FONT_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [11:0] s_font_address,
    input  logic [7:0]  s_font_byte,
    input  logic [7:0]  s_char_code,
    input  logic [6:0]  s_line_index,
    input  logic        s_first_in_row,
    input  logic        s_last_in_row,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol,
    output logic [6:0]  m_repeat_count,
    output logic        m_last
);

    sgr_pkg::cfg_t   cfg_reg, cfg_next;
    sgr_pkg::entry_t push_data;
    sgr_pkg::entry_t job_data;
    logic            push_valid;
    logic            push_ready;
    logic            job_valid;
    logic            job_ready;

    // Clamp a written scale into 1..hi
    function automatic logic [3:0] clamp_scale(input logic [3:0] v, input int hi);
        if (v == 4'd0) begin
            return 4'd1;
        end else if (32'(v) > hi) begin
            return 4'(hi);
        end else begin
            return v;
        end
    endfunction

    // Configuration registers; a write to an unknown index is dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                sgr_pkg::REG_LARGE_FONT:    cfg_next.large_font = cfg_data[0];
                sgr_pkg::REG_WIDTH_SCALE: begin
                    cfg_next.width_scale = clamp_scale(cfg_data[3:0], sgr_pkg::MAX_WIDTH);
                end
                sgr_pkg::REG_HEIGHT_SCALE: begin
                    cfg_next.height_scale = clamp_scale(cfg_data[3:0], sgr_pkg::MAX_HEIGHT);
                end
                sgr_pkg::REG_SLANT_MODE:    cfg_next.slant_mode    = cfg_data[1:0];
                sgr_pkg::REG_INVERT_PIXELS: cfg_next.invert_pixels = cfg_data[0];
                sgr_pkg::REG_FORE_SYMBOL:   cfg_next.fore_symbol   = cfg_data;
                sgr_pkg::REG_BACK_SYMBOL:   cfg_next.back_symbol   = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.large_font    <= 1'b0;
            cfg_reg.width_scale   <= 4'd1;
            cfg_reg.height_scale  <= 4'd1;
            cfg_reg.slant_mode    <= sgr_pkg::SLANT_UPRIGHT;
            cfg_reg.invert_pixels <= 1'b0;
            cfg_reg.fore_symbol   <= 8'd42;
            cfg_reg.back_symbol   <= 8'd32;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: font writes, row divide, glyph fetch
    sgr_front #(
        .FONT_DEPTH (FONT_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_font_address (s_font_address),
        .s_font_byte    (s_font_byte),
        .s_char_code    (s_char_code),
        .s_line_index   (s_line_index),
        .s_first_in_row (s_first_in_row),
        .s_last_in_row  (s_last_in_row),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Decouple fetch from run emission
    sgr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (job_valid),
        .out_ready (job_ready),
        .out_data  (job_data)
    );

    // Back end: one run per cycle into the output register unless m_ready stalls
    sgr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job_data       (job_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol       (m_symbol),
        .m_repeat_count (m_repeat_count),
        .m_last         (m_last)
    );

endmodule

/* src/sgr_checker.sv */
// Port-level checks of the renderer's result channel, bound to the top level.
// Depends only on the top level's ports.
module sgr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_symbol,
    input logic [6:0] m_repeat_count,
    input logic       m_last
);

    logic [3:0] res_cnt_reg, res_cnt_next;
    logic       m_take;

    assign m_take = m_valid && m_ready;

    // Count results of the current render transaction
    always_comb begin
        res_cnt_next = res_cnt_reg;
        if (m_take) begin
            res_cnt_next = m_last ? 4'd0 : res_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_cnt_reg <= 4'd0;
        end else begin
            res_cnt_reg <= res_cnt_next;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) &&
        $stable(m_repeat_count) && $stable(m_last))
        else $error("stalled result changed");

    a_min_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take && m_last |-> res_cnt_reg >= 4'd7)
        else $error("fewer than eight runs for a character");

    a_max_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take && !m_last |-> res_cnt_reg <= 4'd9)
        else $error("more than eleven runs for a character");

endmodule

bind scaled_glyph_row_renderer_unit sgr_checker u_sgr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_symbol       (m_symbol),
    .m_repeat_count (m_repeat_count),
    .m_last         (m_last)
);
